// File: design/dual_stack_rotate_engine_defines.svh
// Assertion macros for the dual stack rotate engine.
// Included by the top level; no other dependencies.
`ifndef DUAL_STACK_ROTATE_ENGINE_DEFINES_SVH
`define DUAL_STACK_ROTATE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define DSRE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled while in reset
`define DSRE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DSRE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DSRE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: design/dsre_pkg.sv
// Shared constants, types and ring-slot helper for the dual stack rotate engine.
// No dependencies.
package dsre_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int OP_W        = 3;
    localparam int IDX_W       = 6;

    typedef logic [PTR_W-1:0]         t_ptr;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [OP_W-1:0]          t_op;
    typedef logic [IDX_W-1:0]         t_idx;

    // operation codes
    localparam t_op OP_SWAP = 3'd0;
    localparam t_op OP_PUSH = 3'd1;
    localparam t_op OP_ROT  = 3'd2;
    localparam t_op OP_RROT = 3'd3;
    localparam t_op OP_LOAD = 3'd4;
    localparam t_op OP_PEEK = 3'd5;

    // controller to datapath commands
    typedef struct packed {
        logic latch;   // capture the input beat
        logic exec;    // check sizes, issue the memory read
        logic fin;     // write memory, update tops and pointers
        logic fin2;    // second write of a swap
    } t_ctrl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic second_write;
    } t_dp_status;

    // ring slot of entry k counted from the bottom
    function automatic t_ptr slot_of(t_ptr bot, t_cnt k);
        logic [CNT_W:0] sum;
        sum = {1'b0, CNT_W'(bot)} + {1'b0, k};
        if (sum >= (CNT_W + 1)'(STACK_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(STACK_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// File: design/dsre_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/dsre_ctrl.sv
// Sequencer for the dual stack rotate engine: accept, execute, finish, swap tail.
// Depends on dsre_pkg.
module dsre_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  dsre_pkg::t_dp_status   i_status,
    output dsre_pkg::t_ctrl_cmd    o_cmd,
    output logic                   o_busy,
    output logic                   o_result_valid
);
    import dsre_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_FIN   = 4'b0100,
        S_SWAP2 = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_state = i_status.second_write ? S_SWAP2 : S_IDLE;
            end
            S_SWAP2: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // raise the result strobe on the cycle after the last update
    assign n_valid = ((r_state == S_FIN) && !i_status.second_write) ||
                     (r_state == S_SWAP2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // commands to the datapath
    always_comb begin
        o_cmd.latch = (r_state == S_IDLE) && i_start;
        o_cmd.exec  = (r_state == S_EXEC);
        o_cmd.fin   = (r_state == S_FIN);
        o_cmd.fin2  = (r_state == S_SWAP2);
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_valid;

endmodule

// File: design/dsre_dp.sv
// Datapath of the dual stack rotate engine: two ring-buffer RAMs, cached tops,
// bottom pointers and fill counts. Depends on dsre_pkg and dsre_ram.
module dsre_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dsre_pkg::t_ctrl_cmd  i_cmd,
    input  dsre_pkg::t_op        i_op,
    input  logic                 i_target,
    input  dsre_pkg::t_word      i_value,
    input  dsre_pkg::t_idx       i_depth_index,
    output dsre_pkg::t_dp_status o_status,
    output dsre_pkg::t_word      o_top_of_a,
    output dsre_pkg::t_word      o_top_of_b,
    output dsre_pkg::t_cnt       o_count_a,
    output dsre_pkg::t_cnt       o_count_b,
    output dsre_pkg::t_word      o_peek_value,
    output logic                 o_no_effect
);
    import dsre_pkg::*;

    // latched input beat
    t_op   r_op;
    logic  r_tgt;
    t_word r_val;
    t_idx  r_didx;

    // step state
    logic  r_ok, n_ok;
    logic  r_flag, n_flag;
    t_word r_peek, n_peek;
    t_word r_tmp, n_tmp;

    // stack state
    t_word r_top_a, r_top_b, n_top_a, n_top_b;
    t_ptr  r_bot_a, r_bot_b, n_bot_a, n_bot_b;
    t_cnt  r_fill_a, r_fill_b, n_fill_a, n_fill_b;

    // target / other views
    t_word top_t, top_o, rd_t;
    t_ptr  bot_t, bot_o;
    t_cnt  fill_t, fill_o;
    logic  op_ok;

    // memory ports
    t_cnt  k_rd, k_wr;
    t_ptr  wr_base, rd_addr, wr_addr;
    t_word wr_data;
    logic  wr_en, wr_sel;
    logic [WORD_W-1:0] rdata_a, rdata_b;

    // next values seen from the target side
    t_word nt_top, no_top;
    t_cnt  nt_fill, no_fill;
    t_ptr  nt_bot;

    // capture the input beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_op;
            r_tgt  <= i_target;
            r_val  <= i_value;
            r_didx <= i_depth_index;
        end
    end

    assign top_t  = r_tgt ? r_top_b  : r_top_a;
    assign top_o  = r_tgt ? r_top_a  : r_top_b;
    assign bot_t  = r_tgt ? r_bot_b  : r_bot_a;
    assign bot_o  = r_tgt ? r_bot_a  : r_bot_b;
    assign fill_t = r_tgt ? r_fill_b : r_fill_a;
    assign fill_o = r_tgt ? r_fill_a : r_fill_b;
    assign rd_t   = r_tgt ? t_word'(rdata_b) : t_word'(rdata_a);

    // size checks
    always_comb begin
        case (r_op)
            OP_SWAP, OP_ROT, OP_RROT: op_ok = (fill_t > t_cnt'(1));
            OP_PUSH: op_ok = (fill_t != '0) && (fill_o < t_cnt'(STACK_DEPTH));
            OP_LOAD: op_ok = (fill_t < t_cnt'(STACK_DEPTH));
            OP_PEEK: op_ok = (32'(r_didx) < 32'(fill_t));
            default: op_ok = 1'b0;
        endcase
    end

    // read address: entry below the top, the bottom, or the peeked entry
    always_comb begin
        case (r_op)
            OP_SWAP, OP_PUSH, OP_ROT: begin
                k_rd = (fill_t > t_cnt'(1)) ? fill_t - t_cnt'(2) : '0;
            end
            OP_PEEK: begin
                k_rd = op_ok ? fill_t - t_cnt'(1) - t_cnt'(r_didx) : '0;
            end
            default: begin
                k_rd = '0;
            end
        endcase
    end

    assign rd_addr = slot_of(bot_t, k_rd);

    // write address and data
    always_comb begin
        wr_en   = 1'b0;
        wr_base = bot_t;
        k_wr    = fill_t;
        wr_data = top_t;
        if (i_cmd.fin2) begin
            wr_en   = 1'b1;
            k_wr    = fill_t - t_cnt'(1);
            wr_data = r_tmp;
        end else if (i_cmd.fin && r_ok) begin
            case (r_op)
                OP_SWAP: begin
                    wr_en = 1'b1;
                    k_wr  = fill_t - t_cnt'(2);
                end
                OP_PUSH: begin
                    wr_en   = 1'b1;
                    wr_base = bot_o;
                    k_wr    = fill_o;
                end
                OP_ROT: begin
                    wr_en = 1'b1;
                    k_wr  = t_cnt'(STACK_DEPTH - 1);
                end
                OP_RROT: begin
                    wr_en   = 1'b1;
                    wr_data = rd_t;
                end
                OP_LOAD: begin
                    wr_en   = 1'b1;
                    wr_data = r_val;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    assign wr_addr = slot_of(wr_base, k_wr);
    assign wr_sel  = (r_op == OP_PUSH) ? ~r_tgt : r_tgt;

    dsre_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (wr_en && !wr_sel),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rdata_a)
    );

    dsre_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (wr_en && wr_sel),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rdata_b)
    );

    // update tops, pointers and fills
    always_comb begin
        nt_top  = top_t;
        no_top  = top_o;
        nt_fill = fill_t;
        no_fill = fill_o;
        nt_bot  = bot_t;
        n_ok    = r_ok;
        n_flag  = r_flag;
        n_peek  = r_peek;
        n_tmp   = r_tmp;
        if (i_cmd.exec) begin
            n_ok   = op_ok;
            n_flag = !op_ok;
            n_peek = '0;
        end
        if (i_cmd.fin && r_ok) begin
            case (r_op)
                OP_SWAP: begin
                    n_tmp = rd_t;
                end
                OP_PUSH: begin
                    nt_top  = (fill_t > t_cnt'(1)) ? rd_t : '0;
                    nt_fill = fill_t - t_cnt'(1);
                    no_top  = top_t;
                    no_fill = fill_o + t_cnt'(1);
                end
                OP_ROT: begin
                    nt_top = rd_t;
                    nt_bot = slot_of(bot_t, t_cnt'(STACK_DEPTH - 1));
                end
                OP_RROT: begin
                    nt_top = rd_t;
                    nt_bot = slot_of(bot_t, t_cnt'(1));
                end
                OP_LOAD: begin
                    nt_top  = r_val;
                    nt_fill = fill_t + t_cnt'(1);
                end
                OP_PEEK: begin
                    n_peek = rd_t;
                end
                default: begin
                    n_peek = r_peek;
                end
            endcase
        end
        if (i_cmd.fin2) begin
            nt_top = r_tmp;
        end
    end

    // map target/other back onto A and B
    assign n_top_a  = r_tgt ? no_top  : nt_top;
    assign n_top_b  = r_tgt ? nt_top  : no_top;
    assign n_fill_a = r_tgt ? no_fill : nt_fill;
    assign n_fill_b = r_tgt ? nt_fill : no_fill;
    assign n_bot_a  = r_tgt ? r_bot_a : nt_bot;
    assign n_bot_b  = r_tgt ? nt_bot  : r_bot_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_a  <= '0;
            r_top_b  <= '0;
            r_bot_a  <= '0;
            r_bot_b  <= '0;
            r_fill_a <= '0;
            r_fill_b <= '0;
            r_ok     <= 1'b0;
            r_flag   <= 1'b0;
            r_peek   <= '0;
        end else begin
            r_top_a  <= n_top_a;
            r_top_b  <= n_top_b;
            r_bot_a  <= n_bot_a;
            r_bot_b  <= n_bot_b;
            r_fill_a <= n_fill_a;
            r_fill_b <= n_fill_b;
            r_ok     <= n_ok;
            r_flag   <= n_flag;
            r_peek   <= n_peek;
        end
    end

    // swap scratch word
    always_ff @(posedge i_clk) begin
        r_tmp <= n_tmp;
    end

    assign o_status.second_write = r_ok && (r_op == OP_SWAP);

    assign o_top_of_a   = r_top_a;
    assign o_top_of_b   = r_top_b;
    assign o_count_a    = r_fill_a;
    assign o_count_b    = r_fill_b;
    assign o_peek_value = r_peek;
    assign o_no_effect  = r_flag;

endmodule

// File: design/dual_stack_rotate_engine.sv
// Each item passes through accept, execute and finish, plus a second write for a swap;
// a new item is taken only once busy has fallen, since the single read port of each
// stack RAM and the two writes a swap makes are used in turn.
// Reset (synchronous, active low) empties both stacks; stack RAM is not cleared.
// The receiver cannot stall: each result beat is shown for one cycle only.
// Depends on dsre_pkg, dsre_ctrl, dsre_dp and the defines header.
`include "dual_stack_rotate_engine_defines.svh"

module dual_stack_rotate_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  dsre_pkg::t_op     i_op,
    input  logic              i_target,
    input  dsre_pkg::t_word   i_value,
    input  dsre_pkg::t_idx    i_depth_index,
    output logic              o_result_valid,
    output dsre_pkg::t_word   o_top_of_a,
    output dsre_pkg::t_word   o_top_of_b,
    output dsre_pkg::t_cnt    o_count_a,
    output dsre_pkg::t_cnt    o_count_b,
    output dsre_pkg::t_word   o_peek_value,
    output logic              o_no_effect
);
    import dsre_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    dsre_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_status       (status),
        .o_cmd          (cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    dsre_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_op          (i_op),
        .i_target      (i_target),
        .i_value       (i_value),
        .i_depth_index (i_depth_index),
        .o_status      (status),
        .o_top_of_a    (o_top_of_a),
        .o_top_of_b    (o_top_of_b),
        .o_count_a     (o_count_a),
        .o_count_b     (o_count_b),
        .o_peek_value  (o_peek_value),
        .o_no_effect   (o_no_effect)
    );

    // checks
    `DSRE_ASSERT_NXT(a_accept_goes_busy, i_clk, i_rst_n, start && !busy, busy, "accepted beat did not raise busy")
    `DSRE_ASSERT_IMP(a_done_strobes, i_clk, i_rst_n, $fell(busy), o_result_valid, "busy fell without a result beat")
    `DSRE_ASSERT_IMP(a_empty_a_zero, i_clk, i_rst_n, o_count_a == '0, o_top_of_a == '0, "empty stack A shows a nonzero top")
    `DSRE_ASSERT_IMP(a_empty_b_zero, i_clk, i_rst_n, o_count_b == '0, o_top_of_b == '0, "empty stack B shows a nonzero top")
    `DSRE_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, (o_count_a <= t_cnt'(STACK_DEPTH)) && (o_count_b <= t_cnt'(STACK_DEPTH)), "stack fill exceeds depth")

endmodule
